FILE: rtl/cep_pkg.sv
// ----------------------------------------------------------------------------
// cep_pkg
// shared widths, register codes, result type and the crc-16 byte update
// ----------------------------------------------------------------------------
package cep_pkg;

  localparam int ADDR_W           = 12;
  localparam int LEN_W            = 9;
  localparam int BYTE_W           = 8;
  localparam int CRC_W            = 16;
  localparam int MAX_PACKET_BYTES = 256;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 12;
  localparam int FIFO_DEPTH       = 4;
  localparam int PTR_W            = $clog2(FIFO_DEPTH);
  localparam int CNT_W            = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_PUSH         = 3;

  localparam logic [CRC_W-1:0] CRC16_GENERATOR = 16'h8005;
  localparam logic [LEN_W-1:0] MAX_LEN         = LEN_W'(MAX_PACKET_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_MODE = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] mem_address;
    logic [BYTE_W-1:0] out_byte;
    logic              is_checksum;
    logic              last;
    logic              checksum_ok;
  } result_t;

  // 24-bit shift register form: crc in the upper 16 bits, byte below
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W+BYTE_W-1:0] r;
    r = {crc, data};
    for (int i = 0; i < BYTE_W; i++) begin
      if (r[CRC_W+BYTE_W-1]) begin
        r = {r[CRC_W+BYTE_W-2:0], 1'b0} ^ {CRC16_GENERATOR, {BYTE_W{1'b0}}};
      end else begin
        r = {r[CRC_W+BYTE_W-2:0], 1'b0};
      end
    end
    return r[CRC_W+BYTE_W-1:BYTE_W];
  endfunction

endpackage

FILE: rtl/crc16_checked_eeprom_packet.sv
// ----------------------------------------------------------------------------
// crc16_checked_eeprom_packet
// crc-16 checked packet streamer for a byte-addressed nonvolatile memory
// ----------------------------------------------------------------------------
// usage:
//   s_* carries packet bytes in; m_* carries one transaction per memory byte
//   with its address. configure base_address, packet_length and
//   transfer_mode through cfg_we/cfg_index/cfg_data between packets.
//   write mode: each data byte gives one result; the final data byte gives
//   three (data, crc low, crc high with tlast).
//   read mode: data bytes, then the stored crc low and high bytes; the high
//   byte carries tlast and the compare flag.
// timing:
//   an accepted byte is processed in the accept cycle (byte-wide crc update)
//   and its results land in a four-entry output queue; with an empty queue
//   the first result is on m_* in the cycle after the accept. throughput is
//   one byte per cycle while m_tready stays high; after a final write-mode
//   byte the input waits until the queue drains the extra checksum results.
// reset and stall:
//   rst empties the queue and returns to the first packet byte with default
//   registers. while m_tready is low the queue holds; s_tready drops once
//   fewer than three entries are free.
// ----------------------------------------------------------------------------
module crc16_checked_eeprom_packet
  import cep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // mem_address[11:0], out_byte[19:12], zero[23:20]
  output logic [1:0]            m_tuser,   // is_checksum[0], checksum_ok[1]
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ADDR_W-1:0] base_address;
  logic [LEN_W-1:0]  packet_length;
  logic              transfer_mode;

  logic [CRC_W-1:0]  crc_value, crc_value_next;
  logic [LEN_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] stored_crc_low, stored_crc_low_next;

  result_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  result_t           res [MAX_PUSH];
  logic [1:0]        push_count;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W:0]    idx_inc;
  logic [CRC_W-1:0]  crc_fed;
  logic [ADDR_W-1:0] addr0;
  logic              accept, pop;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= CNT_W'(FIFO_DEPTH - MAX_PUSH));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      packet_length <= LEN_W'(1);
      transfer_mode <= MODE_WRITE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_ADDRESS:  base_address  <= cfg_data[ADDR_W-1:0];
        REG_PACKET_LENGTH: packet_length <= cfg_data[LEN_W-1:0];
        REG_TRANSFER_MODE: transfer_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (packet_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (packet_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = packet_length;
    end
    idx_inc = {1'b0, byte_index} + (LEN_W+1)'(1);
    crc_fed = crc_update(crc_value, s_tdata);
    addr0   = base_address + ADDR_W'(byte_index);

    crc_value_next      = crc_value;
    byte_index_next     = byte_index;
    stored_crc_low_next = stored_crc_low;
    push_count          = 2'd1;
    for (int k = 0; k < MAX_PUSH; k++) begin
      res[k] = '0;
    end
    res[0].mem_address = addr0;
    res[0].out_byte    = s_tdata;

    if (transfer_mode == MODE_WRITE) begin
      crc_value_next = crc_fed;
      if (idx_inc >= {1'b0, len_eff}) begin
        push_count         = 2'd3;
        res[1].mem_address = addr0 + ADDR_W'(1);
        res[1].out_byte    = crc_fed[7:0];
        res[1].is_checksum = 1'b1;
        res[2].mem_address = addr0 + ADDR_W'(2);
        res[2].out_byte    = crc_fed[15:8];
        res[2].is_checksum = 1'b1;
        res[2].last        = 1'b1;
        crc_value_next      = '0;
        byte_index_next     = '0;
        stored_crc_low_next = '0;
      end else begin
        byte_index_next = idx_inc[LEN_W-1:0];
      end
    end else if (byte_index < len_eff) begin
      crc_value_next  = crc_fed;
      byte_index_next = idx_inc[LEN_W-1:0];
    end else if (byte_index == len_eff) begin
      res[0].is_checksum  = 1'b1;
      stored_crc_low_next = s_tdata;
      byte_index_next     = idx_inc[LEN_W-1:0];
    end else begin
      res[0].is_checksum  = 1'b1;
      res[0].last         = 1'b1;
      res[0].checksum_ok  = ({s_tdata, stored_crc_low} == crc_value);
      crc_value_next      = '0;
      byte_index_next     = '0;
      stored_crc_low_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value      <= '0;
      byte_index     <= '0;
      stored_crc_low <= '0;
    end else if (accept) begin
      crc_value      <= crc_value_next;
      byte_index     <= byte_index_next;
      stored_crc_low <= stored_crc_low_next;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
        if (k < int'(push_count)) begin
          fifo[wr_ptr + PTR_W'(k)] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_W'(push_count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (accept ? CNT_W'(push_count) : CNT_W'(0))
                     - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = {4'b0000, fifo[rd_ptr].out_byte, fifo[rd_ptr].mem_address};
  assign m_tuser  = {fifo[rd_ptr].checksum_ok, fifo[rd_ptr].is_checksum};
  assign m_tlast  = fifo[rd_ptr].last;

endmodule

FILE: rtl/cep_checker.sv
// ----------------------------------------------------------------------------
// cep_checker
// port-level checks on the result stream of the packet streamer
// ----------------------------------------------------------------------------
module cep_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // queue is empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // compare flag only on the final checksum byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0])
    else $error("checksum_ok outside final checksum byte");

  // every packet ends on a checksum byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("packet end on a data byte");

endmodule

bind crc16_checked_eeprom_packet cep_checker u_cep_checker (.*);
